>>> sv/interpolation_search_table_macros.svh
// Assertion macros for the interpolation search table.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef INTERPOLATION_SEARCH_TABLE_MACROS_SVH
`define INTERPOLATION_SEARCH_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is held.
`define ISP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("interpolation_search_table: assertion failed");
// Next-cycle implication, disabled while reset is held.
`define ISP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("interpolation_search_table: assertion failed");
`else
`define ISP_ASSERT_IMP(lbl, ante, cons)
`define ISP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/isp_pkg.sv
// Package for the interpolation search table: field widths, defaults,
// opcode, sequencer state and divider status types. Depends on nothing.
`timescale 1ns / 1ps
package isp_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int WORD_WIDTH_DEF  = 32;

    localparam int IDX_W = 12;
    localparam int LEN_W = 13;
    localparam int VAL_W = 32;
    localparam int POS_W = 12;

    typedef enum logic [0:0] {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } t_isp_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_CHECK,
        S_DIV,
        S_RD_MID,
        S_CMP,
        S_DONE
    } t_isp_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_isp_div_status;

endpackage

>>> sv/isp_mem.sv
// Word table storage: one write port, one registered read port.
// Depends on isp_pkg for its default sizes.
`timescale 1ns / 1ps
module isp_mem #(
    parameter int DEPTH = isp_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = isp_pkg::WORD_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/isp_div.sv
// Serial scaled-quotient unit: floor(d * r / s) by shift, add and reduce,
// with a doubling step and an add step for each bit of r. Depends on isp_pkg.
`timescale 1ns / 1ps
module isp_div #(
    parameter int WIDTH = isp_pkg::WORD_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [WIDTH-1:0]             i_d,
    input  logic [isp_pkg::POS_W-1:0]    i_r,
    input  logic [WIDTH-1:0]             i_s,
    output logic [isp_pkg::POS_W-1:0]    o_q,
    output isp_pkg::t_isp_div_status     o_status
);
    import isp_pkg::*;

    localparam int CW = $clog2(POS_W);

    logic             r_busy;
    logic             r_done;
    logic             r_phase;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_d;
    logic [WIDTH-1:0] r_s;
    logic [POS_W-1:0] r_r;
    logic [POS_W-1:0] r_q;

    logic [WIDTH-1:0] s_minus_rem;
    logic             dbl_wrap;
    logic             add_wrap;

    // The remainder always stays below s, so s - rem never wraps and the
    // comparisons below stand in for the overflowing sums.
    assign s_minus_rem = r_s - r_rem;
    assign dbl_wrap    = (r_rem >= s_minus_rem);
    assign add_wrap    = (r_d >= s_minus_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= '0;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (r_cnt == CW'(POS_W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= '0;
            r_d   <= i_d;
            r_s   <= i_s;
            r_r   <= i_r;
        end else if (r_busy) begin
            if (!r_phase) begin
                // Double the remainder modulo s.
                if (dbl_wrap) begin
                    r_rem <= r_rem - s_minus_rem;
                end else begin
                    r_rem <= r_rem + r_rem;
                end
                r_q <= {r_q[POS_W-2:0], dbl_wrap};
            end else begin
                // Add d modulo s when the current bit of r is set.
                if (r_r[POS_W-1]) begin
                    if (add_wrap) begin
                        r_rem <= r_d - s_minus_rem;
                        r_q   <= r_q + 1'b1;
                    end else begin
                        r_rem <= r_rem + r_d;
                    end
                end
                r_r <= {r_r[POS_W-2:0], 1'b0};
            end
        end
    end

    assign o_q           = r_q;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

>>> sv/interpolation_search_table.sv
// Interpolation search table. A write request is written when accepted and gives no result.
// A search request reads both ends of the window, checks the end values, runs the serial
// divider for the probe offset, reads the probe and compares it, and goes round again until
// the end-value check stops it or a probe hits the key; an empty window goes straight to
// the done state. Each probe costs three table reads, the check, the divider and the compare.
// One request at a time. Reset (synchronous, active low) clears sequencer and output valid.
`timescale 1ns / 1ps
`include "interpolation_search_table_macros.svh"
module interpolation_search_table #(
    parameter int TABLE_DEPTH = isp_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_WIDTH  = isp_pkg::WORD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [0:0]                i_opcode,
    input  logic [isp_pkg::IDX_W-1:0] i_index,
    input  logic [isp_pkg::LEN_W-1:0] i_window_length,
    input  logic [isp_pkg::VAL_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_found,
    output logic [isp_pkg::POS_W-1:0] o_position
);
    import isp_pkg::*;

    // Address width of the table, and a working width wide enough for the
    // table depth itself and for base plus offset.
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = (DW > LEN_W + 1) ? DW : LEN_W + 1;

    t_isp_state        r_state, n_state;
    logic [IDX_W-1:0]  r_base;
    logic [WORD_WIDTH-1:0] r_key;
    logic [WORD_WIDTH-1:0] r_a_lo;
    logic [POS_W-1:0]  r_lo, n_lo;
    logic [POS_W-1:0]  r_hi, n_hi;
    logic [POS_W-1:0]  r_mid, n_mid;
    logic              r_res_found, n_res_found;
    logic [POS_W-1:0]  r_res_pos, n_res_pos;
    logic              r_out_valid;
    logic              r_out_found;
    logic [POS_W-1:0]  r_out_pos;

    logic              in_accept;
    logic              out_free;
    logic [SW-1:0]     base_s;
    logic [SW-1:0]     depth_s;
    logic [SW-1:0]     room;
    logic [SW-1:0]     len_s;
    logic [SW-1:0]     len_clip;
    logic              base_ok;
    logic [POS_W-1:0]  hi_in;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AW-1:0]     mem_raddr;
    logic [POS_W-1:0]  rd_sel;
    logic [WORD_WIDTH-1:0] mem_rdata;

    logic              stop;
    logic              div_start;
    logic [WORD_WIDTH-1:0] div_d;
    logic [WORD_WIDTH-1:0] div_s;
    logic [POS_W-1:0]  div_r;
    logic [POS_W-1:0]  div_q;
    t_isp_div_status   div_st;
    logic              probing;

    // The block takes a request only while the sequencer is idle. A finished
    // result waits in the output register, so the next request may already be
    // taken while the previous result is still stalled.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid & ~o_in_stall;
    assign out_free   = ~r_out_valid | ~i_out_stall;

    // Window clipping: a base beyond the table gives an empty window, and a
    // window running past the table end is cut at the last entry.
    assign base_s   = SW'(i_index);
    assign depth_s  = SW'(TABLE_DEPTH);
    assign base_ok  = (base_s < depth_s);
    assign room     = depth_s - base_s;
    assign len_s    = SW'(i_window_length);
    assign len_clip = (len_s > room) ? room : len_s;
    assign hi_in    = POS_W'(len_clip - 1'b1);

    // Writes go straight to the table in the cycle they are accepted; a write
    // beyond the table is dropped.
    assign mem_we    = in_accept & (i_opcode == OP_WRITE) & base_ok;
    assign mem_waddr = AW'(base_s);

    // The read address follows the sequencer: the low end, the high end or
    // the probe. The read data are registered and come back in the next cycle.
    always_comb begin
        case (r_state)
            S_RD_HI:  rd_sel = r_hi;
            S_RD_MID: rd_sel = r_mid;
            default:  rd_sel = r_lo;
        endcase
    end

    assign mem_raddr = AW'(SW'(r_base) + SW'(rd_sel));

    isp_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (WORD_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (WORD_WIDTH'(i_value)),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // In the check state the read data hold the high end value. The search
    // stops when the end values match or the key lies outside them;
    // otherwise the divider is started on the probe offset.
    assign stop      = (mem_rdata == r_a_lo) || (r_key < r_a_lo) || (r_key > mem_rdata);
    assign div_start = (r_state == S_CHECK) & ~stop;
    assign div_d     = r_key - r_a_lo;
    assign div_s     = mem_rdata - r_a_lo;
    assign div_r     = r_hi - r_lo;

    isp_div #(
        .WIDTH (WORD_WIDTH)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_d      (div_d),
        .i_r      (div_r),
        .i_s      (div_s),
        .o_q      (div_q),
        .o_status (div_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: read both ends, check, divide, read the probe, compare,
    // and either narrow the window and go round again or finish.
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res_found = r_res_found;
        n_res_pos   = r_res_pos;
        case (r_state)
            S_IDLE: begin
                if (in_accept && (i_opcode == OP_SEARCH)) begin
                    n_lo        = '0;
                    n_hi        = hi_in;
                    n_res_found = 1'b0;
                    n_res_pos   = '0;
                    if (base_ok && (len_clip != '0)) begin
                        n_state = S_RD_LO;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RD_LO: begin
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (stop) begin
                    n_res_found = (r_key == r_a_lo);
                    n_res_pos   = (r_key == r_a_lo) ? r_lo : '0;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_mid   = r_lo + div_q;
                    n_state = S_RD_MID;
                end
            end
            S_RD_MID: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (mem_rdata < r_key) begin
                    n_lo    = r_mid + 1'b1;
                    n_state = S_RD_LO;
                end else if (r_key < mem_rdata) begin
                    n_hi    = r_mid - 1'b1;
                    n_state = S_RD_LO;
                end else begin
                    n_res_found = 1'b1;
                    n_res_pos   = r_mid;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Working registers of the search; they carry payload only.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_base <= i_index;
            r_key  <= WORD_WIDTH'(i_value);
        end
        if (r_state == S_RD_HI) begin
            r_a_lo <= mem_rdata;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_res_found <= n_res_found;
        r_res_pos   <= n_res_pos;
    end

    // Output register: loaded from the done state once it is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_found <= r_res_found;
            r_out_pos   <= r_res_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_position  = r_out_pos;

    // The states in which a probe is being set up or divided.
    assign probing = (r_state == S_RD_LO) || (r_state == S_RD_HI) ||
                     (r_state == S_CHECK) || (r_state == S_DIV);

    // The window never inverts while a probe is in progress.
    `ISP_ASSERT_IMP(a_lo_le_hi, probing, r_lo <= r_hi)
    // The probe always falls inside the current window.
    `ISP_ASSERT_IMP(a_mid_in_window, r_state == S_RD_MID, (r_mid >= r_lo) && (r_mid <= r_hi))
    // The divider reports completion only to a sequencer waiting on it.
    `ISP_ASSERT_IMP(a_div_done_in_div, div_st.done, r_state == S_DIV)
    // A started division keeps the divider busy in the next cycle.
    `ISP_ASSERT_NXT(a_div_busy, div_start, div_st.busy)

endmodule

>>> tb/sv/tb_interpolation_search_table.sv
// Self-checking testbench for the interpolation search table: loads ascending
// runs of words, searches windows over them and checks every result.
// Depends on isp_pkg and the interpolation_search_table RTL.
`timescale 1ns / 1ps
module tb_interpolation_search_table;
    import isp_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int CLK_HALF  = 10;
    // Generous upper bound on the whole run, in nanoseconds.
    localparam longint RUN_LIMIT_NS = 64'd60_000_000;
    // Cycles allowed after the last result for anything unexpected to appear.
    localparam int DRAIN_CYCLES = 64;
    // Length of the receiver hold-off that fills the block up.
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int RANDOM_ITEMS = 400;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    // The scoreboard keeps its own copy of the table, updated as write
    // requests are accepted, and predicts each search when it is accepted.
    class search_scoreboard;
        bit [VAL_W-1:0] table_words [DEPTH];
        search_result_t expected_results [$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(string what);
            $display("ERROR at %0t ns: %s", $realtime, what);
            errors++;
        endtask

        function int pending();
            return expected_results.size();
        endfunction

        // Interpolation search over the clipped window; the product of the
        // key offset and the index span is kept exact in 64 bits.
        function search_result_t predict_search(bit [IDX_W-1:0] base,
                                                bit [LEN_W-1:0] len_in,
                                                bit [VAL_W-1:0] key_in);
            search_result_t r;
            longint unsigned span, lo, hi, mid, a_lo, a_hi, a_mid, key;
            r = '0;
            key = key_in;
            span = len_in;
            if (span > DEPTH - base) span = DEPTH - base;
            if (span == 0) return r;
            lo = 0;
            hi = span - 1;
            forever begin
                a_lo = table_words[base + lo];
                a_hi = table_words[base + hi];
                if (a_hi == a_lo || key < a_lo || key > a_hi) break;
                mid = lo + ((key - a_lo) * (hi - lo)) / (a_hi - a_lo);
                a_mid = table_words[base + mid];
                if (a_mid < key) begin
                    lo = mid + 1;
                end else if (key < a_mid) begin
                    hi = mid - 1;
                end else begin
                    r.found = 1'b1;
                    r.position = mid[POS_W-1:0];
                    return r;
                end
            end
            if (key == table_words[base + lo]) begin
                r.found = 1'b1;
                r.position = lo[POS_W-1:0];
            end
            return r;
        endfunction

        function void note_request(t_isp_op op, bit [IDX_W-1:0] idx,
                                   bit [LEN_W-1:0] len, bit [VAL_W-1:0] val);
            if (op == OP_WRITE) begin
                if (idx < DEPTH) table_words[idx] = val;
            end else begin
                expected_results.push_back(predict_search(idx, len, val));
            end
        endfunction

        task check_result(logic found, logic [POS_W-1:0] position);
            search_result_t exp_r;
            if (expected_results.size() == 0) begin
                report($sformatf("result found=%0b position=%0d with no search pending",
                                 found, position));
                return;
            end
            exp_r = expected_results.pop_front();
            if (found !== exp_r.found)
                report($sformatf("found is %0b, expected %0b", found, exp_r.found));
            if (position !== exp_r.position)
                report($sformatf("position is %0d, expected %0d",
                                 position, exp_r.position));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [0:0]           i_opcode;
    logic [IDX_W-1:0]     i_index;
    logic [LEN_W-1:0]     i_window_length;
    logic [VAL_W-1:0]     i_value;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_found;
    logic [POS_W-1:0]     o_position;

    search_scoreboard sb = new();

    // Idle percentages of the two sides, and the receiver hold-off flag.
    int send_idle_pct = 24;
    int recv_idle_pct = 80;
    int idle_phase    = 0;
    bit hold_off      = 1'b0;
    int items_sent    = 0;

    // The stimulus side keeps a shadow of what it has written, so that it
    // only ever searches windows whose every entry holds a defined word.
    bit [VAL_W-1:0] gen_words   [DEPTH];
    bit             gen_written [DEPTH];

    interpolation_search_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_index         (i_index),
        .i_window_length (i_window_length),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_position      (o_position)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // The receiver stalls at random, or solidly while the hold-off runs.
    always @(negedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Both handshakes are observed at the rising edge, where the values
    // driven at the falling edge have long settled.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_request(t_isp_op'(i_opcode), i_index, i_window_length, i_value);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_found, o_position);
    end

    // Once the last phase begins, the receiver holds off for a long stretch.
    // The block can only work on one request at a time, so it soon stalls
    // the sender, which keeps offering requests all the while.
    initial begin
        wait (idle_phase == 2);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("interpolation_search_table: mismatch");
        $finish;
    end

    function int clipped_len(int base, int len);
        return (len > DEPTH - base) ? DEPTH - base : len;
    endfunction

    function bit window_ready(int base, int len);
        int n;
        n = clipped_len(base, len);
        for (int k = 0; k < n; k++)
            if (!gen_written[base + k]) return 1'b0;
        return 1'b1;
    endfunction

    // Offers one request and returns at the rising edge that accepts it.
    // The valid stays high into the next request unless an idle gap is drawn.
    task send_request(t_isp_op op, int idx, int len, bit [VAL_W-1:0] val);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (op == OP_WRITE) begin
            gen_words[idx]   = val;
            gen_written[idx] = 1'b1;
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_index         <= idx[IDX_W-1:0];
        i_window_length <= len[LEN_W-1:0];
        i_value         <= val;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Writes a run of non-decreasing words, saturating at the top of the range.
    task load_run(int start, int count, bit [VAL_W-1:0] first_word, int incr_max);
        longint unsigned v;
        v = first_word;
        for (int k = 0; k < count; k++) begin
            send_request(OP_WRITE, start + k, 0, v[VAL_W-1:0]);
            v = v + $urandom_range(0, incr_max);
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        end
    endtask

    // One search inside a freshly loaded segment. Segments at the end of the
    // table sometimes get an oversized length so that the window is clipped.
    task search_segment(int seg_start, int seg_len, bit at_end);
        int base, rem, len, n;
        bit [VAL_W-1:0] key, a_lo, a_hi;
        base = seg_start + $urandom_range(0, seg_len - 1);
        rem  = seg_start + seg_len - base;
        len  = $urandom_range(1, rem);
        if (at_end && $urandom_range(0, 3) == 0) len = $urandom_range(rem, 8191);
        n    = clipped_len(base, len);
        a_lo = gen_words[base];
        a_hi = gen_words[base + n - 1];
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: key = gen_words[base + $urandom_range(0, n - 1)];
            6, 7:             key = $urandom_range(a_lo, a_hi);
            8:                key = (a_lo > 0) ? $urandom_range(0, a_lo - 1) : $urandom;
            default:          key = (a_hi < 32'hFFFF_FFFF) ?
                                    $urandom_range(a_hi + 1, 32'hFFFF_FFFF) : $urandom;
        endcase
        send_request(OP_SEARCH, base, len, key);
    endtask

    initial begin
        int seg_len, seg_start, incr_max, base, len, n_search;
        bit at_end;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = OP_WRITE;
        i_index         = '0;
        i_window_length = '0;
        i_value         = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A short ascending run with a repeated word, both
        // extreme words and a large jump.
        send_request(OP_WRITE, 0, 0, 32'd0);
        send_request(OP_WRITE, 1, 0, 32'd10);
        send_request(OP_WRITE, 2, 0, 32'd20);
        send_request(OP_WRITE, 3, 0, 32'd20);
        send_request(OP_WRITE, 4, 0, 32'd40);
        send_request(OP_WRITE, 5, 0, 32'd1000);
        send_request(OP_WRITE, 6, 0, 32'd70000);
        send_request(OP_WRITE, 7, 0, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 0, 8, 32'd0);
        send_request(OP_SEARCH, 0, 8, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, 0, 8, 32'd40);
        // A key between two words is not found, with position zero.
        send_request(OP_SEARCH, 0, 8, 32'd35);
        // An empty window reports not found.
        send_request(OP_SEARCH, 2, 0, 32'd20);
        // Both ends of the window hold the same word.
        send_request(OP_SEARCH, 2, 2, 32'd20);
        send_request(OP_SEARCH, 1, 1, 32'd10);
        send_request(OP_SEARCH, 0, 1, 32'd1);
        // The last table entries; an oversized window is clipped at the end.
        send_request(OP_WRITE, DEPTH - 2, 0, 32'd5);
        send_request(OP_WRITE, DEPTH - 1, 0, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, DEPTH - 2, 4096, 32'hFFFF_FFFF);
        send_request(OP_SEARCH, DEPTH - 1, 4096, 32'd3);
        send_request(OP_SEARCH, DEPTH - 1, 0, 32'd0);
        // An unsorted stretch must still give a defined answer.
        send_request(OP_WRITE, 8, 0, 32'd500);
        send_request(OP_WRITE, 9, 0, 32'd100);
        send_request(OP_WRITE, 10, 0, 32'd300);
        send_request(OP_SEARCH, 8, 3, 32'd300);

        // Random part: mostly loads of a sorted segment followed by searches
        // within it, with stray writes and searches mixed in as noise.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (idle_phase == 0 && items_sent >= RANDOM_ITEMS / 3) begin
                idle_phase    = 1;
                send_idle_pct = 80;
                recv_idle_pct = 24;
            end else if (idle_phase == 1 && items_sent >= 2 * RANDOM_ITEMS / 3) begin
                idle_phase    = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(0, 9) < 8) begin
                seg_len   = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48)
                                                        : $urandom_range(1, 24);
                at_end    = ($urandom_range(0, 4) == 0);
                seg_start = at_end ? DEPTH - seg_len : $urandom_range(0, DEPTH - seg_len);
                case ($urandom_range(0, 4))
                    0:       incr_max = 0;
                    1:       incr_max = 3;
                    2:       incr_max = 1000;
                    3:       incr_max = 1 << 20;
                    default: incr_max = 1 << 26;
                endcase
                load_run(seg_start, seg_len,
                         ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(0, 32'h7FFF_FFFF),
                         incr_max);
                n_search = $urandom_range(2, 8);
                repeat (n_search) search_segment(seg_start, seg_len, at_end);
            end else if ($urandom_range(0, 1) == 0) begin
                // A stray write may leave part of the table unsorted.
                send_request(OP_WRITE, $urandom_range(0, DEPTH - 1), $urandom_range(0, 8191),
                             $urandom);
            end else begin
                base = $urandom_range(0, DEPTH - 1);
                len  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 16);
                // A window over entries never written is turned into an empty one.
                if (!window_ready(base, len)) len = 0;
                send_request(OP_SEARCH, base, len, $urandom);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("interpolation_search_table: match");
        end else begin
            $display("interpolation_search_table: mismatch");
        end
        $finish;
    end
endmodule
